// ----- hw/rtl/spq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the sorted priority queue
// Default sizes, request modes and response status codes.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned CAPACITY_DEFAULT      = 16;
  localparam int unsigned PAYLOAD_BITS_DEFAULT  = 32;
  localparam int unsigned PRIORITY_BITS_DEFAULT = 16;

  localparam int unsigned STATUS_BITS = 2;

  typedef enum logic {
    MODE_ENQUEUE = 1'b0,
    MODE_DEQUEUE = 1'b1
  } mode_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

// ----- hw/rtl/spq_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_if: request and response channels of the sorted priority queue
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface spq_req_if #(
  parameter int unsigned PAYLOAD_BITS  = 32,
  parameter int unsigned PRIORITY_BITS = 16
);
  logic                            valid;
  logic                            ready;
  logic                            mode;
  logic [PAYLOAD_BITS-1:0]         payload;
  logic signed [PRIORITY_BITS-1:0] priority_req;

  modport source (output valid, mode, payload, priority_req, input ready);
  modport sink   (input valid, mode, payload, priority_req, output ready);
endinterface

interface spq_rsp_if #(
  parameter int unsigned PAYLOAD_BITS = 32,
  parameter int unsigned COUNT_BITS   = 5
);
  logic                    valid;
  logic                    ready;
  logic [1:0]              status;
  logic [PAYLOAD_BITS-1:0] out_payload;
  logic [PAYLOAD_BITS-1:0] head_payload;
  logic                    is_empty;
  logic [COUNT_BITS-1:0]   entry_count;

  modport source (output valid, status, out_payload, head_payload, is_empty, entry_count,
                  input ready);
  modport sink   (input valid, status, out_payload, head_payload, is_empty, entry_count,
                  output ready);
endinterface

// ----- hw/rtl/spq_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue
// Holds one entry; compares against the incoming priority and either keeps
// its entry, takes the new one, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
#(
  parameter int unsigned PAYLOAD_BITS  = PAYLOAD_BITS_DEFAULT,
  parameter int unsigned PRIORITY_BITS = PRIORITY_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic                            dequeue,
  input  logic                            occupied,
  input  logic signed [PRIORITY_BITS-1:0] new_prio,
  input  logic [PAYLOAD_BITS-1:0]         new_payload,
  input  logic                            left_keep,
  input  logic signed [PRIORITY_BITS-1:0] left_prio,
  input  logic [PAYLOAD_BITS-1:0]         left_payload,
  input  logic signed [PRIORITY_BITS-1:0] right_prio,
  input  logic [PAYLOAD_BITS-1:0]         right_payload,
  output logic                            keep,
  output logic signed [PRIORITY_BITS-1:0] prio,
  output logic [PAYLOAD_BITS-1:0]         payload,
  output logic [PAYLOAD_BITS-1:0]         payload_next
);

  logic signed [PRIORITY_BITS-1:0] prio_next;
  logic [PAYLOAD_BITS-1:0]         cand_payload;

  // keep flags form a prefix of the row, since entries are sorted
  assign keep = occupied && (prio >= new_prio);

  always_comb begin
    if (dequeue) begin
      prio_next    = right_prio;
      cand_payload = right_payload;
    end else if (keep) begin
      prio_next    = prio;
      cand_payload = payload;
    end else if (left_keep) begin
      prio_next    = new_prio;
      cand_payload = new_payload;
    end else begin
      prio_next    = left_prio;
      cand_payload = left_payload;
    end
  end

  assign payload_next = en ? cand_payload : payload;

  always_ff @(posedge clk) begin
    if (en) begin
      prio    <= prio_next;
      payload <= cand_payload;
    end
  end

endmodule

// ----- hw/rtl/sorted_priority_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue, highest priority at the head
// A row of compare-and-shift cells kept in sorted order.
// ----------------------------------------------------------------------------
// Takes one request (enqueue or dequeue) per clock and returns one response
// per request from an output register. Every cell compares its entry with
// the incoming priority in parallel, so an enqueue inserts and shifts the
// tail together and a dequeue shifts the row toward the head. Equal
// priorities leave first in, first out. An enqueue into a full queue answers
// status full and changes nothing; a dequeue on an empty queue answers status
// empty with a zero payload. No clearing pass after reset: the entry count
// alone marks which cells hold entries. The input is stalled only while a
// response waits unread.
// ----------------------------------------------------------------------------
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY      = CAPACITY_DEFAULT,
  parameter int unsigned PAYLOAD_BITS  = PAYLOAD_BITS_DEFAULT,
  parameter int unsigned PRIORITY_BITS = PRIORITY_BITS_DEFAULT
) (
  input  logic     clk,
  input  logic     rst,
  spq_req_if.sink  req,
  spq_rsp_if.source rsp
);

  localparam int unsigned COUNT_BITS = $clog2(CAPACITY + 1);

  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_next;

  logic                            accept;
  logic                            is_deq;
  logic                            full;
  logic                            empty;
  logic                            update;
  status_t                         status_next;
  logic [PAYLOAD_BITS-1:0]         removed;
  logic [PAYLOAD_BITS-1:0]         head_next;

  logic                            keep     [CAPACITY];
  logic signed [PRIORITY_BITS-1:0] prio     [CAPACITY];
  logic [PAYLOAD_BITS-1:0]         payload  [CAPACITY];
  logic [PAYLOAD_BITS-1:0]         pay_next [CAPACITY];

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign is_deq    = (req.mode == MODE_DEQUEUE);
  assign full      = (count == COUNT_BITS'(CAPACITY));
  assign empty     = (count == '0);

  always_comb begin
    if (is_deq) begin
      status_next = empty ? ST_EMPTY : ST_DONE;
    end else begin
      status_next = full ? ST_FULL : ST_DONE;
    end
  end

  assign update = accept && (status_next == ST_DONE);

  always_comb begin
    if (!update) begin
      count_next = count;
    end else if (is_deq) begin
      count_next = count - COUNT_BITS'(1);
    end else begin
      count_next = count + COUNT_BITS'(1);
    end
  end

  assign removed   = (is_deq && !empty) ? payload[0] : '0;
  assign head_next = (count_next != '0) ? pay_next[0] : '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                            l_keep;
    logic signed [PRIORITY_BITS-1:0] l_prio;
    logic [PAYLOAD_BITS-1:0]         l_payload;
    logic signed [PRIORITY_BITS-1:0] r_prio;
    logic [PAYLOAD_BITS-1:0]         r_payload;

    // head cell sees a virtual keeping neighbor, so it takes the new entry
    if (i == 0) begin : g_head
      assign l_keep    = 1'b1;
      assign l_prio    = req.priority_req;
      assign l_payload = req.payload;
    end else begin : g_body
      assign l_keep    = keep[i-1];
      assign l_prio    = prio[i-1];
      assign l_payload = payload[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_prio    = prio[i];
      assign r_payload = payload[i];
    end else begin : g_inner
      assign r_prio    = prio[i+1];
      assign r_payload = payload[i+1];
    end

    spq_cell #(
      .PAYLOAD_BITS (PAYLOAD_BITS),
      .PRIORITY_BITS(PRIORITY_BITS)
    ) u_cell (
      .clk          (clk),
      .en           (update),
      .dequeue      (is_deq),
      .occupied     (count > COUNT_BITS'(i)),
      .new_prio     (req.priority_req),
      .new_payload  (req.payload),
      .left_keep    (l_keep),
      .left_prio    (l_prio),
      .left_payload (l_payload),
      .right_prio   (r_prio),
      .right_payload(r_payload),
      .keep         (keep[i]),
      .prio         (prio[i]),
      .payload      (payload[i]),
      .payload_next (pay_next[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status       <= status_next;
      rsp.out_payload  <= removed;
      rsp.head_payload <= head_next;
      rsp.is_empty     <= (count_next == '0);
      rsp.entry_count  <= count_next;
    end
  end

endmodule

// ----- hw/rtl/spq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker: port-level checks for the sorted priority queue
// Consistency of response fields and response hold under stall.
// ----------------------------------------------------------------------------
module spq_checker
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY     = CAPACITY_DEFAULT,
  parameter int unsigned PAYLOAD_BITS = PAYLOAD_BITS_DEFAULT,
  parameter int unsigned COUNT_BITS   = $clog2(CAPACITY_DEFAULT + 1)
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    rsp_valid,
  input logic                    rsp_ready,
  input logic [1:0]              status,
  input logic [PAYLOAD_BITS-1:0] out_payload,
  input logic                    is_empty,
  input logic [COUNT_BITS-1:0]   entry_count
);

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (is_empty == (entry_count == '0)))
    else $error("is_empty disagrees with entry_count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (entry_count <= COUNT_BITS'(CAPACITY)))
    else $error("entry_count above capacity");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == ST_FULL) |-> (entry_count == COUNT_BITS'(CAPACITY)))
    else $error("full status with room left");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == ST_EMPTY) |-> (is_empty && out_payload == '0))
    else $error("empty status with entries or payload");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(out_payload) && $stable(status)))
    else $error("response changed while stalled");

endmodule

bind sorted_priority_queue spq_checker #(
  .CAPACITY    (CAPACITY),
  .PAYLOAD_BITS(PAYLOAD_BITS),
  .COUNT_BITS  ($clog2(CAPACITY + 1))
) u_spq_checker (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .status     (rsp.status),
  .out_payload(rsp.out_payload),
  .is_empty   (rsp.is_empty),
  .entry_count(rsp.entry_count)
);
